[src/bls_pkg.sv]
// Shared types and constants for the Bresenham line stepper.
package bls_pkg;

   localparam int COORD_BITS     = 10;
   localparam int DEC_BITS       = COORD_BITS + 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0]    coord_type;
   typedef logic signed [DEC_BITS-1:0] decision_type;

   typedef enum logic [0:0] {
      FUNC_START = 1'b0,
      FUNC_STEP  = 1'b1
   } func_type;

   typedef struct packed {
      func_type  func;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last;
   } rsp_type;

   // classified request, as held in the queue between front and back
   typedef struct packed {
      logic         is_start;
      logic         steep;
      logic         minor_down;
      coord_type    major_start;
      coord_type    minor_start;
      coord_type    major_end;
      coord_type    delta_major;
      coord_type    delta_minor;
      decision_type decision;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic line_active;
   } back_status_type;

endpackage

[src/bresenham_line_stepper.sv]
// A request is written into the queue entry register, and its pixel is then registered at the output.
// Throughput: one request per cycle while rsp_ready is high; a step request with no line
// active gives no pixel. The two-entry request queue and the output register set the rate.
// Reset (synchronous, active high) drops any line in progress, empties the queue
// and clears the output valid; no clearing pass.
module bresenham_line_stepper (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bls_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bls_pkg::rsp_type rsp_payload
);
   import bls_pkg::*;

   logic             push_valid, push_ready;
   cmd_type          push_data;
   logic             pop_valid, pop_ready;
   cmd_type          pop_data;
   queue_status_type q_status;
   back_status_type  b_status;

   bls_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   bls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .status     (q_status)
   );

   bls_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .status      (b_status)
   );

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   a_last_vs_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (b_status.line_active == !rsp_payload.last))
      else $error("line state disagrees with last mark of held pixel");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !b_status.line_active && q_status.empty))
      else $error("reset did not clear block");

   a_no_pop_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_payload))
      else $error("held pixel overwritten");

endmodule

[src/bls_front.sv]
// Front end: classifies requests and sets up octant, deltas and decision for a start.
module bls_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  bls_pkg::req_type req_payload,
   output logic             push_valid,
   input  logic             push_ready,
   output bls_pkg::cmd_type push_data
);
   import bls_pkg::*;

   coord_type adx, ady;
   coord_type ma0, mi0, ma1, mi1;
   coord_type ord_ma0, ord_mi0, ord_ma1, ord_mi1;
   logic      steep, swap, down;
   coord_type dmaj, dmin;

   always_comb begin
      adx = (req_payload.end_x >= req_payload.start_x) ?
            req_payload.end_x - req_payload.start_x :
            req_payload.start_x - req_payload.end_x;
      ady = (req_payload.end_y >= req_payload.start_y) ?
            req_payload.end_y - req_payload.start_y :
            req_payload.start_y - req_payload.end_y;
      steep = (ady > adx);
      if (steep) begin
         ma0 = req_payload.start_y;
         mi0 = req_payload.start_x;
         ma1 = req_payload.end_y;
         mi1 = req_payload.end_x;
      end else begin
         ma0 = req_payload.start_x;
         mi0 = req_payload.start_y;
         ma1 = req_payload.end_x;
         mi1 = req_payload.end_y;
      end
      swap = (ma0 > ma1);
      ord_ma0 = swap ? ma1 : ma0;
      ord_mi0 = swap ? mi1 : mi0;
      ord_ma1 = swap ? ma0 : ma1;
      ord_mi1 = swap ? mi0 : mi1;
      down = (ord_mi1 < ord_mi0);
      dmaj = ord_ma1 - ord_ma0;
      dmin = down ? ord_mi0 - ord_mi1 : ord_mi1 - ord_mi0;

      push_data.is_start    = (req_payload.func == FUNC_START);
      push_data.steep       = steep;
      push_data.minor_down  = down;
      push_data.major_start = ord_ma0;
      push_data.minor_start = ord_mi0;
      push_data.major_end   = ord_ma1;
      push_data.delta_major = dmaj;
      push_data.delta_minor = dmin;
      push_data.decision    = signed'({2'b00, dmin, 1'b0}) - signed'({3'b000, dmaj});
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

[src/bls_queue.sv]
// Short FIFO of classified requests between front and back.
module bls_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  bls_pkg::cmd_type          push_data,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output bls_pkg::cmd_type          pop_data,
   output bls_pkg::queue_status_type status
);
   import bls_pkg::*;

   cmd_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   function automatic logic [QUEUE_PTR_BITS-1:0] next_ptr(input logic [QUEUE_PTR_BITS-1:0] p);
      if (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QUEUE_PTR_BITS'(1);
   endfunction

   always_comb begin
      push_ready   = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
      pop_valid    = (count_ff != '0);
      pop_data     = entry_ff[rd_ptr_ff];
      do_push      = push_valid && push_ready;
      do_pop       = pop_valid && pop_ready;
      wr_ptr_in    = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
      status.full  = !push_ready;
      status.empty = !pop_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/bls_back.sv]
// Back end: line state, per-pixel decision update and registered result.
module bls_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  bls_pkg::cmd_type         pop_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bls_pkg::rsp_type         rsp_payload,
   output bls_pkg::back_status_type status
);
   import bls_pkg::*;

   coord_type    major_ff, major_in;
   coord_type    minor_ff, minor_in;
   coord_type    major_end_ff, major_end_in;
   coord_type    dmaj_ff, dmaj_in;
   coord_type    dmin_ff, dmin_in;
   decision_type decision_ff, decision_in;
   logic         steep_ff, steep_in;
   logic         down_ff, down_in;
   logic         active_ff, active_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_payload_ff, rsp_payload_in;

   logic         out_free, fire, emit, fin;
   decision_type twice_min, twice_diff;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      pop_ready    = out_free;
      fire         = pop_valid && out_free;

      major_in     = major_ff;
      minor_in     = minor_ff;
      major_end_in = major_end_ff;
      dmaj_in      = dmaj_ff;
      dmin_in      = dmin_ff;
      decision_in  = decision_ff;
      steep_in     = steep_ff;
      down_in      = down_ff;
      emit         = 1'b0;

      twice_min  = signed'({2'b00, dmin_ff, 1'b0});
      twice_diff = twice_min - signed'({2'b00, dmaj_ff, 1'b0});

      if (fire && pop_data.is_start) begin
         emit         = 1'b1;
         major_in     = pop_data.major_start;
         minor_in     = pop_data.minor_start;
         major_end_in = pop_data.major_end;
         dmaj_in      = pop_data.delta_major;
         dmin_in      = pop_data.delta_minor;
         decision_in  = pop_data.decision;
         steep_in     = pop_data.steep;
         down_in      = pop_data.minor_down;
      end else if (fire && active_ff) begin
         emit = 1'b1;
         if (decision_ff[DEC_BITS-1]) begin
            decision_in = decision_ff + twice_min;
         end else begin
            decision_in = decision_ff + twice_diff;
            minor_in    = down_ff ? minor_ff - COORD_BITS'(1) : minor_ff + COORD_BITS'(1);
         end
         major_in = major_ff + COORD_BITS'(1);
      end

      fin = (major_in == major_end_in);

      active_in      = emit ? !fin : active_ff;
      rsp_valid_in   = emit || (rsp_valid_ff && !rsp_ready);
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_payload_in.pixel_x = steep_in ? minor_in : major_in;
         rsp_payload_in.pixel_y = steep_in ? major_in : minor_in;
         rsp_payload_in.last    = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      major_ff       <= major_in;
      minor_ff       <= minor_in;
      major_end_ff   <= major_end_in;
      dmaj_ff        <= dmaj_in;
      dmin_ff        <= dmin_in;
      decision_ff    <= decision_in;
      steep_ff       <= steep_in;
      down_ff        <= down_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_payload_ff;
   assign status.line_active = active_ff;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the Bresenham line stepper: directed and random line requests, pixel checks.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bls_pkg::*;

   typedef struct {
      bit          hold;
      int unsigned gap;
      req_type     req;
   } stim_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   stim_type    stim_q[$];
   rsp_type     pixel_q[$];
   int unsigned gap_count = 0;
   int unsigned stall_count = 0;
   bit          rsp_quiet = 1'b0;
   bit          line_quiet = 1'b0;
   bit          hold_next = 1'b0;
   int          failures = 0;
   int          counted = 0;

   // predictor state
   coord_type line_major, line_minor, line_major_end;
   int        line_dmajor, line_dminor, line_err;
   bit        line_steep, line_down, line_live;

   bresenham_line_stepper DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void emit_pixel();
      rsp_type px;
      px.pixel_x = line_steep ? line_minor : line_major;
      px.pixel_y = line_steep ? line_major : line_minor;
      px.last    = (line_major == line_major_end);
      line_live  = !px.last;
      pixel_q.push_back(px);
   endfunction

   function automatic void predict_pixel(req_type r);
      int sx, sy, ex, ey, adx, ady, ma0, mi0, ma1, mi1, t;
      if (r.func == FUNC_START) begin
         sx = r.start_x;
         sy = r.start_y;
         ex = r.end_x;
         ey = r.end_y;
         adx = (ex >= sx) ? ex - sx : sx - ex;
         ady = (ey >= sy) ? ey - sy : sy - ey;
         line_steep = (ady > adx);
         if (line_steep) begin
            ma0 = sy; mi0 = sx; ma1 = ey; mi1 = ex;
         end else begin
            ma0 = sx; mi0 = sy; ma1 = ex; mi1 = ey;
         end
         if (ma0 > ma1) begin
            t = ma0; ma0 = ma1; ma1 = t;
            t = mi0; mi0 = mi1; mi1 = t;
         end
         line_down      = (mi1 < mi0);
         line_dmajor    = ma1 - ma0;
         line_dminor    = line_down ? mi0 - mi1 : mi1 - mi0;
         line_major     = coord_type'(ma0);
         line_minor     = coord_type'(mi0);
         line_major_end = coord_type'(ma1);
         line_err       = 2 * line_dminor - line_dmajor;
         emit_pixel();
      end else if (line_live) begin
         if (line_err < 0) begin
            line_err += 2 * line_dminor;
         end else begin
            line_err += 2 * (line_dminor - line_dmajor);
            line_minor = line_down ? line_minor - 1'b1 : line_minor + 1'b1;
         end
         line_major = line_major + 1'b1;
         emit_pixel();
      end
   endfunction

   task automatic push_req(req_type r, bit counts);
      stim_type s;
      s.req  = r;
      s.gap  = line_quiet ? 0 : idle_len();
      s.hold = hold_next;
      hold_next = 1'b0;
      stim_q.push_back(s);
      if (counts) counted++;
   endtask

   task automatic push_step(bit counts);
      req_type r;
      r.func    = FUNC_STEP;
      r.start_x = coord_type'($urandom);
      r.start_y = coord_type'($urandom);
      r.end_x   = coord_type'($urandom);
      r.end_y   = coord_type'($urandom);
      push_req(r, counts);
   endtask

   // start request plus steps; steps < 0 runs the line to its end
   task automatic push_line(int sx, int sy, int ex, int ey, int steps);
      req_type r;
      int      len;
      r.func    = FUNC_START;
      r.start_x = coord_type'(sx);
      r.start_y = coord_type'(sy);
      r.end_x   = coord_type'(ex);
      r.end_y   = coord_type'(ey);
      push_req(r, 1'b1);
      len = (sx > ex) ? sx - ex : ex - sx;
      if (((sy > ey) ? sy - ey : ey - sy) > len) len = (sy > ey) ? sy - ey : ey - sy;
      if (steps < 0 || steps > len) steps = len;
      repeat (steps) push_step(1'b1);
   endtask

   function automatic int near_coord(int base, int span);
      int off, c;
      off = $urandom_range(0, 2 * span) - span;
      c = base + off;
      if (c < 0 || c > 1023) c = base - off;
      return c;
   endfunction

   // request driver
   always @(posedge clock) begin
      stim_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count <= 0;
      end else begin
         if (req_valid && req_ready) predict_pixel(req_payload);
         if (req_valid && !req_ready) begin
         end else if (gap_count != 0) begin
            req_valid <= 1'b0;
            gap_count <= gap_count - 1;
         end else if (stim_q.size() == 0 || (stim_q[0].hold && pixel_q.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            nxt = stim_q.pop_front();
            req_valid   <= 1'b1;
            req_payload <= nxt.req;
            gap_count   <= nxt.gap;
         end
      end
   end

   // pixel monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_count <= 0;
         rsp_quiet   <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               $error("unexpected pixel x=%0d y=%0d last=%0d",
                      rsp_payload.pixel_x, rsp_payload.pixel_y, rsp_payload.last);
               failures++;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_payload.pixel_x !== want.pixel_x) begin
                  $error("pixel_x expected %0d got %0d", want.pixel_x, rsp_payload.pixel_x);
                  failures++;
               end
               if (rsp_payload.pixel_y !== want.pixel_y) begin
                  $error("pixel_y expected %0d got %0d", want.pixel_y, rsp_payload.pixel_y);
                  failures++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, rsp_payload.last);
                  failures++;
               end
            end
         end
         if ($urandom_range(0, 199) == 0) rsp_quiet <= !rsp_quiet;
         if (stall_count != 0) begin
            rsp_ready   <= 1'b0;
            stall_count <= stall_count - 1;
         end else begin
            rsp_ready   <= 1'b1;
            stall_count <= rsp_quiet ? 0 : idle_len();
         end
      end
   end

   initial begin
      int kind, sx, sy, span, next_hold;
      req_type r;

      // directed
      push_step(1'b0);
      push_line(0, 0, 0, 0, -1);
      push_step(1'b0);
      push_line(1023, 1023, 1023, 1023, -1);
      push_line(0, 0, 3, 1, -1);
      push_line(0, 0, 2, 1, -1);
      push_line(1023, 0, 1021, 3, -1);
      push_line(1023, 1020, 1020, 1023, -1);
      push_line(10, 10, 20, 15, 2);
      push_line(0, 1023, 1, 1021, -1);
      push_step(1'b0);
      hold_next = 1'b1;

      // random
      next_hold = 300;
      while (counted < 1700) begin
         if (counted >= next_hold) begin
            hold_next = 1'b1;
            next_hold += 300 + $urandom_range(0, 200);
         end
         line_quiet = ($urandom_range(0, 7) == 0);
         kind = $urandom_range(0, 99);
         sx = $urandom_range(0, 1023);
         sy = $urandom_range(0, 1023);
         span = ($urandom_range(0, 3) == 0) ? 3 : $urandom_range(1, 24);
         if (kind < 80) begin
            push_line(sx, sy, near_coord(sx, span), near_coord(sy, span), -1);
         end else if (kind < 83) begin
            span = $urandom_range(100, 1023);
            push_line(sx, sy, near_coord(sx, span), near_coord(sy, span), -1);
         end else if (kind < 91) begin
            push_line(sx, sy, near_coord(sx, span), near_coord(sy, span),
                      $urandom_range(0, span));
         end else if (kind < 96) begin
            repeat ($urandom_range(1, 3)) push_step(1'b0);
         end else begin
            r.func    = FUNC_START;
            r.start_x = coord_type'($urandom);
            r.start_y = coord_type'($urandom);
            r.end_x   = coord_type'($urandom);
            r.end_y   = coord_type'($urandom);
            push_req(r, 1'b1);
            repeat ($urandom_range(0, 3)) push_step(1'b1);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (stim_q.size() != 0 || req_valid || pixel_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && pixel_q.size() == 0) begin
         $display("bresenham_line_stepper: match");
      end else begin
         $display("bresenham_line_stepper: mismatch");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("bresenham_line_stepper: mismatch");
      $finish;
   end

endmodule
